/* design/acll_pkg.sv */
// Package for the associative cache with LRU/LFU replacement.
// Holds command codes, policy codes, register indexes and the control structs.
// No dependencies.
package acll_pkg;

    // Request command codes.
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Replacement policy codes; the other codes always replace entry zero.
    localparam logic [1:0] POL_LRU = 2'd0;
    localparam logic [1:0] POL_LFU = 2'd1;

    // Configuration register indexes and widths.
    localparam logic CFG_POLICY  = 1'b0;
    localparam logic CFG_ENTRIES = 1'b1;
    localparam int   CFG_DW      = 5;
    localparam int   POLICY_W    = 2;
    localparam int   ENTRIES_W   = 5;
    localparam logic [ENTRIES_W-1:0] ENTRIES_RST = 5'd16;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                clear;    // write zeros at the index
        logic                capture;  // latch the accepted request
        logic                issue;    // read all arrays at the index
        logic                write;    // commit the update and load the response
        logic [POLICY_W-1:0] policy;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;  // response register full and not taken this cycle
    } t_dp_sts;

    // Saturating increment of a 32-bit counter.
    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == SAT32) ? v : v + 32'd1;
    endfunction

endpackage

/* design/acll_if.sv */
// Request and response channel interfaces of the associative cache.
// Uses nothing from the package; payload widths are those of the fields.
interface acll_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] lookup_key;
    logic signed [63:0] store_value;

    modport source (output valid, command, lookup_key, store_value, input ready);
    modport sink   (input valid, command, lookup_key, store_value, output ready);
endinterface

interface acll_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic signed [63:0] read_value;
    logic [3:0]  slot;
    logic [31:0] hit_total;
    logic [31:0] miss_total;

    modport source (output valid, hit, read_value, slot, hit_total, miss_total,
                    input ready);
    modport sink   (input valid, hit, read_value, slot, hit_total, miss_total,
                    output ready);
endinterface

/* design/acll_ctrl.sv */
// Controller of the associative cache: clear sweep, scan sequencing, update.
// Also owns the configuration registers. Depends on acll_pkg.
module acll_ctrl
    import acll_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output t_ctl_cmd          o_cmd,
    output logic [IW-1:0]     o_idx,
    input  t_dp_sts           i_sts
);

    localparam int LW = (IW + 1 > ENTRIES_W) ? IW + 1 : ENTRIES_W;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_FINISH = 5'b01000,
        S_UPDATE = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [IW-1:0]         r_cnt, n_cnt;
    logic [IW-1:0]         r_last;
    logic [POLICY_W-1:0]   r_policy;
    logic [ENTRIES_W-1:0]  r_entries;
    logic [LW-1:0]         w_n;
    logic [IW-1:0]         w_last;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= POL_LRU;
            r_entries <= ENTRIES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLICY:  r_policy  <= i_cfg_data[POLICY_W-1:0];
                CFG_ENTRIES: r_entries <= i_cfg_data[ENTRIES_W-1:0];
                default:     r_policy  <= r_policy;
            endcase
        end
    end

    // Active entry count, clamped to one through ENTRIES, as a last index.
    always_comb begin
        w_n = LW'(r_entries);
        if (r_entries == '0) begin
            w_n = LW'(1);
        end
        if (w_n > LW'(ENTRIES)) begin
            w_n = LW'(ENTRIES);
        end
        w_last = IW'(w_n - LW'(1));
    end

    // Next state and scan counter.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.policy = r_policy;
        o_req_ready  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (r_cnt == IW'(ENTRIES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + IW'(1);
                end
            end
            S_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
                n_cnt         = '0;
                if (i_req_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (r_cnt == r_last) begin
                    n_state = S_FINISH;
                end else begin
                    n_cnt = r_cnt + IW'(1);
                end
            end
            S_FINISH: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.write = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idx = r_cnt;

    // State registers; the entry count is sampled when a request is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (o_cmd.capture) begin
                r_last <= w_last;
            end
        end
    end

endmodule

/* design/acll_dpath.sv */
// Datapath of the associative cache: entry memories, scan compare, counters
// and the response register. Depends on acll_pkg.
module acll_dpath
    import acll_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl_cmd           i_cmd,
    input  logic [IW-1:0]      i_idx,
    output t_dp_sts            o_sts,
    input  logic               i_command,
    input  logic [63:0]        i_lookup_key,
    input  logic signed [63:0] i_store_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_hit,
    output logic signed [63:0] o_read_value,
    output logic [3:0]         o_slot,
    output logic [31:0]        o_hit_total,
    output logic [31:0]        o_miss_total
);

    // Entry memories.
    logic [63:0] r_keys [ENTRIES];
    logic [63:0] r_vals [ENTRIES];
    logic [31:0] r_ages [ENTRIES];
    logic [31:0] r_uses [ENTRIES];

    // Registered read data.
    logic [63:0] r_key_q, r_val_q;
    logic [31:0] r_age_q, r_use_q;
    logic        r_rd_vld;
    logic [IW-1:0] r_rd_idx;

    // Captured request and scan results.
    logic          r_cmd;
    logic [63:0]   r_key;
    logic [63:0]   r_val;
    logic          r_found;
    logic [IW-1:0] r_slot;
    logic [63:0]   r_hit_val;
    logic [31:0]   r_hit_use;
    logic [31:0]   r_best;

    // Global counters.
    logic [31:0] r_age_clk, r_hit_cnt, r_miss_cnt;
    logic [31:0] n_age_clk, n_hit_cnt, n_miss_cnt;

    // Response register.
    logic               r_out_vld;
    logic               r_out_hit;
    logic signed [63:0] r_out_val;
    logic [3:0]         r_out_slot;
    logic [31:0]        r_out_hits, r_out_miss;

    logic          w_is_hit, w_is_ins, w_lru, w_lfu;
    logic          w_we_kv, w_we_age, w_we_use;
    logic [IW-1:0] w_waddr;
    logic [63:0]   w_wkey, w_wval;
    logic [31:0]   w_wage, w_wuse, w_metric;

    assign w_lru    = (i_cmd.policy == POL_LRU);
    assign w_lfu    = (i_cmd.policy == POL_LFU);
    assign w_is_hit = (r_cmd == CMD_LOOKUP) && r_found;
    assign w_is_ins = (r_cmd == CMD_INSERT);

    // Write port selection: clear sweep or the commit of one request.
    always_comb begin
        w_waddr  = i_cmd.clear ? i_idx : r_slot;
        w_we_kv  = i_cmd.clear || (i_cmd.write && w_is_ins);
        w_we_age = i_cmd.clear || (i_cmd.write && (w_is_hit || (w_is_ins && w_lru)));
        w_we_use = i_cmd.clear || (i_cmd.write && (w_is_hit || (w_is_ins && w_lfu)));
        w_wkey   = i_cmd.clear ? 64'd0 : r_key;
        w_wval   = i_cmd.clear ? 64'd0 : r_val;
        if (i_cmd.clear) begin
            w_wage = 32'd0;
            w_wuse = 32'd0;
        end else if (w_is_hit) begin
            w_wage = r_age_clk;
            w_wuse = sat_inc32(r_hit_use);
        end else begin
            w_wage = sat_inc32(r_age_clk);
            w_wuse = 32'd1;
        end
    end

    // Key and value memories.
    always_ff @(posedge i_clk) begin
        if (w_we_kv) begin
            r_keys[w_waddr] <= w_wkey;
            r_vals[w_waddr] <= w_wval;
        end
        if (i_cmd.issue) begin
            r_key_q <= r_keys[i_idx];
            r_val_q <= r_vals[i_idx];
        end
    end

    // Age memory.
    always_ff @(posedge i_clk) begin
        if (w_we_age) begin
            r_ages[w_waddr] <= w_wage;
        end
        if (i_cmd.issue) begin
            r_age_q <= r_ages[i_idx];
        end
    end

    // Use count memory.
    always_ff @(posedge i_clk) begin
        if (w_we_use) begin
            r_uses[w_waddr] <= w_wuse;
        end
        if (i_cmd.issue) begin
            r_use_q <= r_uses[i_idx];
        end
    end

    // Read data tag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
        end
        r_rd_idx <= i_idx;
    end

    assign w_metric = w_lru ? r_age_q : r_use_q;

    // Request capture and scan evaluation, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_command;
            r_key   <= i_lookup_key;
            r_val   <= i_store_value;
            r_found <= 1'b0;
            r_slot  <= '0;
        end else if (r_rd_vld) begin
            if (r_cmd == CMD_LOOKUP) begin
                // First matching entry wins.
                if (!r_found && (r_key_q == r_key)) begin
                    r_found   <= 1'b1;
                    r_slot    <= r_rd_idx;
                    r_hit_val <= r_val_q;
                    r_hit_use <= r_use_q;
                end
            end else if (w_lru || w_lfu) begin
                // Strictly smaller keeps the lowest index on ties.
                if ((r_rd_idx == '0) || (w_metric < r_best)) begin
                    r_best <= w_metric;
                    r_slot <= r_rd_idx;
                end
            end
        end
    end

    // Next values of the global counters.
    always_comb begin
        n_age_clk  = r_age_clk;
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        if (r_cmd == CMD_LOOKUP) begin
            if (r_found) begin
                n_hit_cnt = sat_inc32(r_hit_cnt);
                n_age_clk = sat_inc32(r_age_clk);
            end else begin
                n_miss_cnt = sat_inc32(r_miss_cnt);
            end
        end else if (w_lru) begin
            n_age_clk = sat_inc32(r_age_clk);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_clk  <= '0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else if (i_cmd.write) begin
            r_age_clk  <= n_age_clk;
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.write) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.write) begin
            r_out_hit  <= w_is_hit;
            r_out_val  <= w_is_hit ? r_hit_val : 64'sd0;
            r_out_slot <= 4'(r_slot);
            r_out_hits <= n_hit_cnt;
            r_out_miss <= n_miss_cnt;
        end
    end

    assign o_sts.out_busy = r_out_vld && !i_ready;
    assign o_valid        = r_out_vld;
    assign o_hit          = r_out_hit;
    assign o_read_value   = r_out_val;
    assign o_slot         = r_out_slot;
    assign o_hit_total    = r_out_hits;
    assign o_miss_total   = r_out_miss;

endmodule

/* design/assoc_cache_lru_lfu.sv */
// Fully associative key/value cache with LRU, LFU or fixed replacement.
// Each request scans the active entries one read per cycle, then commits the update
// and loads the response register, waiting while that register is full and not taken;
// no new request is taken until the commit. Reset: synchronous; after reset a clearing
// pass zeroes the entry memories while no request is taken (config writes still accepted).
module assoc_cache_lru_lfu
    import acll_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    acll_req_if.sink          i_req,
    acll_rsp_if.source        o_rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_ctl_cmd      w_cmd;
    t_dp_sts       w_sts;
    logic [IW-1:0] w_idx;

    // Sequencer.
    acll_ctrl #(
        .ENTRIES(ENTRIES),
        .IW     (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req_valid(i_req.valid),
        .o_req_ready(i_req.ready),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx),
        .i_sts      (w_sts)
    );

    // Entry storage and response datapath.
    acll_dpath #(
        .ENTRIES(ENTRIES),
        .IW     (IW)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_idx        (w_idx),
        .o_sts        (w_sts),
        .i_command    (i_req.command),
        .i_lookup_key (i_req.lookup_key),
        .i_store_value(i_req.store_value),
        .o_valid      (o_rsp.valid),
        .i_ready      (o_rsp.ready),
        .o_hit        (o_rsp.hit),
        .o_read_value (o_rsp.read_value),
        .o_slot       (o_rsp.slot),
        .o_hit_total  (o_rsp.hit_total),
        .o_miss_total (o_rsp.miss_total)
    );

endmodule

/* design/acll_chk.sv */
// Port-level checker for the associative cache, bound to the top level.
// Uses only the top-level ports.
module acll_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_rsp_hit,
    input logic [63:0] i_rsp_read_value,
    input logic [31:0] i_rsp_hit_total
);

    // A stalled response keeps its payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_read_value))
        else $error("response changed while stalled");

    // A response that is not a hit carries a zero value.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_hit |-> i_rsp_read_value == 64'd0)
        else $error("non-hit response carries a value");

    // A hit is always counted.
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_hit |-> i_rsp_hit_total != 32'd0)
        else $error("hit response with zero hit total");

    // The clearing pass holds off requests right after reset.
    a_clear_busy: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !i_req_ready)
        else $error("request taken during clearing pass");

    // A rising response valid never directly follows an accepted request.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> !$past(i_req_valid && i_req_ready))
        else $error("response too soon after request");

endmodule

bind assoc_cache_lru_lfu acll_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_hit       (o_rsp.hit),
    .i_rsp_read_value(o_rsp.read_value),
    .i_rsp_hit_total (o_rsp.hit_total)
);

/* sim/acll_checker.sv */
`timescale 1ns / 1ps
// Response checker for the associative cache: snoops the register port and both
// channels, predicts each response and compares it field by field.
// Depends on acll_pkg and the channel interfaces of acll_if.sv.
module acll_checker
    import acll_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    acll_req_if               i_req,
    acll_rsp_if               i_rsp,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int NUM_ENTRIES = 16;

    // One predicted response.
    typedef struct packed {
        logic               hit;
        logic signed [63:0] read_value;
        logic [3:0]         slot;
        logic [31:0]        hit_total;
        logic [31:0]        miss_total;
    } t_cache_result;

    // Mirror of the cache contents, counters and registers.
    logic [63:0]           key_store   [NUM_ENTRIES];
    logic [63:0]           value_store [NUM_ENTRIES];
    logic [31:0]           age_store   [NUM_ENTRIES];
    logic [31:0]           use_store   [NUM_ENTRIES];
    logic [31:0]           age_tick;
    logic [31:0]           hits_seen;
    logic [31:0]           misses_seen;
    logic [POLICY_W-1:0]   policy_reg;
    logic [ENTRIES_W-1:0]  entries_reg;

    t_cache_result pending_results [$];
    int            mismatch_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [31:0] sat_bump(input logic [31:0] count);
        return (count == 32'hFFFF_FFFF) ? count : count + 32'd1;
    endfunction

    // Applies one request to the mirror and returns the response it should produce.
    function automatic t_cache_result cache_access(input logic cmd, input logic [63:0] key,
                                                   input logic [63:0] data);
        t_cache_result res;
        int            active;
        int            pick;
        bit            found;
        res    = '0;
        found  = 1'b0;
        pick   = 0;
        // An entry count of zero searches one entry; above the size searches all.
        active = (entries_reg == 0) ? 1 :
                 ((entries_reg > NUM_ENTRIES) ? NUM_ENTRIES : int'(entries_reg));
        if (cmd == CMD_LOOKUP) begin
            // Scanning downward leaves the lowest matching index.
            for (int i = active - 1; i >= 0; i--) begin
                if (key_store[i] == key) begin
                    found = 1'b1;
                    pick  = i;
                end
            end
            if (found) begin
                res.hit        = 1'b1;
                res.read_value = value_store[pick];
                res.slot       = pick[3:0];
                hits_seen      = sat_bump(hits_seen);
                use_store[pick] = sat_bump(use_store[pick]);
                age_store[pick] = age_tick;
                age_tick       = sat_bump(age_tick);
            end else begin
                misses_seen = sat_bump(misses_seen);
            end
        end else begin
            // Victim choice; ties go to the lowest index, other policies take entry zero.
            if (policy_reg == POL_LRU) begin
                for (int i = 1; i < active; i++)
                    if (age_store[i] < age_store[pick]) pick = i;
            end else if (policy_reg == POL_LFU) begin
                for (int i = 1; i < active; i++)
                    if (use_store[i] < use_store[pick]) pick = i;
            end
            key_store[pick]   = key;
            value_store[pick] = data;
            if (policy_reg == POL_LRU) begin
                age_tick        = sat_bump(age_tick);
                age_store[pick] = age_tick;
            end else if (policy_reg == POL_LFU) begin
                use_store[pick] = 32'd1;
            end
            res.slot = pick[3:0];
        end
        res.hit_total  = hits_seen;
        res.miss_total = misses_seen;
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] seen);
        if (seen !== want) begin
            $error("%s: expected %h, got %h", field, want, seen);
            mismatch_count++;
        end
    endfunction

    // Track registers, predict on each accepted request, check each accepted response.
    always @(posedge i_clk) begin
        t_cache_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                key_store[i]   = '0;
                value_store[i] = '0;
                age_store[i]   = '0;
                use_store[i]   = '0;
            end
            age_tick    = '0;
            hits_seen   = '0;
            misses_seen = '0;
            policy_reg  = POL_LRU;
            entries_reg = ENTRIES_RST;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_POLICY) policy_reg = i_cfg_data[POLICY_W-1:0];
                else entries_reg = i_cfg_data[ENTRIES_W-1:0];
            end
            // The response of this edge belongs to an earlier request.
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) begin
                    $error("response arrived with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("hit", want.hit, i_rsp.hit);
                    check_field("read_value", want.read_value, i_rsp.read_value);
                    check_field("slot", want.slot, i_rsp.slot);
                    check_field("hit_total", want.hit_total, i_rsp.hit_total);
                    check_field("miss_total", want.miss_total, i_rsp.miss_total);
                end
            end
            if (i_req.valid && i_req.ready)
                pending_results.push_back(cache_access(i_req.command, i_req.lookup_key,
                                                       i_req.store_value));
        end
        o_fail_count <= mismatch_count;
        o_pending    <= pending_results.size();
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the associative cache: clock, reset, register writes and
// request traffic with random stalls; the checker compares every response.
// Depends on acll_pkg, acll_if.sv, the cache RTL and acll_checker.
module tb_top;
    import acll_pkg::*;

    localparam int GAP_MAX        = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int KEY_POOL       = 24;
    localparam int PHASES         = 11;
    localparam int PHASE_ITEMS    = 100;

    // Policy codes that both replace entry zero.
    localparam logic [1:0] POL_ZERO  = 2'd2;
    localparam logic [1:0] POL_SPARE = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic              cfg_idx;
    logic [CFG_DW-1:0] cfg_data;
    int                fail_count;
    int                pending;
    int                idle_cycles = 0;
    bit                gaps_on;
    logic [63:0]       key_pool [KEY_POOL];

    acll_req_if req_ch ();
    acll_rsp_if rsp_ch ();

    assoc_cache_lru_lfu u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    acll_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Stop the run when no request or response moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Response side: random stall bursts while gaps are enabled.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (gaps_on && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Hold off new requests until every response has come back.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Present one request, with an optional idle burst ahead of it.
    task automatic send_request(input logic cmd, input logic [63:0] key,
                                input logic [63:0] data);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= cmd;
        req_ch.lookup_key  <= key;
        req_ch.store_value <= data;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    initial begin : stimulus
        logic [1:0]           policy;
        logic [ENTRIES_W-1:0] entry_count;
        logic                 cmd;
        logic [63:0]          key;

        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_POLICY;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.command     = CMD_LOOKUP;
        req_ch.lookup_key  = '0;
        req_ch.store_value = '0;
        gaps_on            = 1'b1;

        // Key pool: the extremes plus random keys, so lookups hit often.
        key_pool[0] = 64'd0;
        key_pool[1] = '1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        for (int i = 3; i < KEY_POOL; i++) key_pool[i] = rand64();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default LRU over all entries; every entry holds key zero after reset.
        send_request(CMD_LOOKUP, 64'd0, rand64());
        send_request(CMD_LOOKUP, '1, rand64());
        send_request(CMD_INSERT, '1, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(CMD_INSERT, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_request(CMD_LOOKUP, '1, rand64());
        send_request(CMD_LOOKUP, 64'h8000_0000_0000_0000, rand64());
        send_request(CMD_INSERT, 64'd1, '1);
        send_request(CMD_LOOKUP, 64'd1, rand64());
        send_request(CMD_LOOKUP, 64'd0, rand64());

        // LFU restricted to a single entry, then widened so ties pick the lowest index.
        wait_idle();
        write_reg(CFG_POLICY, CFG_DW'(POL_LFU));
        write_reg(CFG_ENTRIES, 5'd1);
        send_request(CMD_INSERT, 64'd2, rand64());
        send_request(CMD_LOOKUP, 64'd2, rand64());
        send_request(CMD_LOOKUP, 64'd1, rand64());
        wait_idle();
        write_reg(CFG_ENTRIES, 5'd16);
        send_request(CMD_INSERT, 64'd3, rand64());
        send_request(CMD_INSERT, 64'd3, rand64());
        send_request(CMD_LOOKUP, 64'd3, rand64());

        // An entry count of zero with the spare policy code.
        wait_idle();
        write_reg(CFG_POLICY, CFG_DW'(POL_SPARE));
        write_reg(CFG_ENTRIES, 5'd0);
        send_request(CMD_INSERT, 64'd4, rand64());
        send_request(CMD_LOOKUP, 64'd4, rand64());
        send_request(CMD_LOOKUP, '1, rand64());

        // Entry count beyond the cache size with the fixed-victim policy.
        wait_idle();
        write_reg(CFG_POLICY, CFG_DW'(POL_ZERO));
        write_reg(CFG_ENTRIES, 5'd31);
        send_request(CMD_INSERT, 64'd5, rand64());
        send_request(CMD_LOOKUP, '1, rand64());
        send_request(CMD_LOOKUP, 64'd5, rand64());

        // Random phases, each with its own settings; the last one runs without gaps.
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            gaps_on = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0, 4:    policy = POL_LRU;
                1, 5:    policy = POL_LFU;
                2:       policy = POL_ZERO;
                default: policy = POL_SPARE;
            endcase
            case ($urandom_range(0, 4))
                0:       entry_count = 5'd16;
                1:       entry_count = 5'd1;
                2:       entry_count = ENTRIES_W'($urandom_range(2, 15));
                3:       entry_count = ENTRIES_W'($urandom_range(0, 31));
                default: entry_count = 5'd16;
            endcase
            write_reg(CFG_POLICY, CFG_DW'(policy));
            write_reg(CFG_ENTRIES, entry_count);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Once, let the pipeline run completely dry mid-phase.
                if (phase == 3 && n == PHASE_ITEMS / 2) wait_idle();
                cmd = ($urandom_range(0, 1) == 0) ? CMD_LOOKUP : CMD_INSERT;
                key = ($urandom_range(0, 9) == 0) ? rand64()
                                                  : key_pool[$urandom_range(0, KEY_POOL - 1)];
                send_request(cmd, key, rand64());
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/acll_pkg.sv
design/acll_if.sv
design/acll_ctrl.sv
design/acll_dpath.sv
design/assoc_cache_lru_lfu.sv
design/acll_chk.sv
sim/acll_checker.sv
sim/tb_top.sv
